@@ hdl/drt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drt_pkg: shared definitions of the deferred request table
// Field widths, command codes, the stored entry layout and the
// controller to datapath command and status groups.
// ----------------------------------------------------------------------------
package drt_pkg;

    // Field widths
    localparam int MAC_W    = 48;
    localparam int IFACE_W  = 8;
    localparam int HANDLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int HOLD_W   = 16;
    localparam int CMD_W    = 2;

    // Defaults
    localparam int ENTRIES_DEF = 16;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd10;

    typedef logic [CMD_W-1:0] t_cmd;

    // Command codes
    localparam t_cmd CMD_SAVE = 2'd0;
    localparam t_cmd CMD_MARK = 2'd1;
    localparam t_cmd CMD_POP  = 2'd2;
    localparam t_cmd CMD_TICK = 2'd3;

    // One stored entry
    typedef struct packed {
        logic [MAC_W-1:0]    mac;
        logic [IFACE_W-1:0]  iface;
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   stamp;
    } t_entry;

    // Controller to datapath strobes
    typedef struct packed {
        logic load;    // latch the request beat
        logic rd_en;   // read the entry store at the scan address
        logic chk;     // evaluate the entry that the last read returned
        logic commit;  // apply the update and load the response
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_busy;  // response register holds a beat that is not taken
    } t_dp_sts;

endpackage

@@ hdl/drt_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drt_req_if: request channel
// Valid/ready channel that carries one table command per beat.
// ----------------------------------------------------------------------------
interface drt_req_if;
    logic                            valid;
    logic                            ready;
    drt_pkg::t_cmd                   command;
    logic [drt_pkg::MAC_W-1:0]       mac_addr;
    logic [drt_pkg::IFACE_W-1:0]     iface_id;
    logic [drt_pkg::HANDLE_W-1:0]    packet_handle;
    logic [drt_pkg::TIME_W-1:0]      now_time;

    modport source (output valid, command, mac_addr, iface_id, packet_handle, now_time,
                    input ready);
    modport sink   (input valid, command, mac_addr, iface_id, packet_handle, now_time,
                    output ready);
endinterface

@@ hdl/drt_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drt_rsp_if: response channel
// Valid/ready channel that carries one command result per beat.
// ----------------------------------------------------------------------------
interface drt_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            status;
    logic [drt_pkg::HANDLE_W-1:0]    handle_out;
    logic [drt_pkg::MAC_W-1:0]       mac_out;

    modport source (output valid, status, handle_out, mac_out, input ready);
    modport sink   (input valid, status, handle_out, mac_out, output ready);
endinterface

@@ hdl/drt_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drt_ram: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module drt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/drt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drt_ctrl: table controller
// Accepts a request beat, sweeps the scan counter over every entry and
// commits the result once the response register is free.
// ----------------------------------------------------------------------------
module drt_ctrl #(
    parameter int ENTRIES = drt_pkg::ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  drt_pkg::t_dp_sts           i_sts,
    output drt_pkg::t_dp_cmd           o_cmd,
    output logic [$clog2(ENTRIES)-1:0] o_rd_addr,
    output logic [$clog2(ENTRIES)-1:0] o_chk_idx
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ENTRIES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] w_prev;

    assign w_prev    = r_cnt - CNT_W'(1);
    assign o_rd_addr = r_cnt[IDX_W-1:0];
    assign o_chk_idx = w_prev[IDX_W-1:0];

    // Next state and strobes
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // read entry cnt, check entry cnt-1 whose data is now back
                o_cmd.rd_en = (r_cnt != CNT_LAST);
                o_cmd.chk   = (r_cnt != '0);
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_FIN;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    a_no_commit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.commit && i_sts.out_busy))
        else $error("commit while response register is occupied");

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_SCAN && r_cnt == '0))
        else $error("accepted beat did not start a scan at entry zero");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_LAST)
        else $error("scan counter beyond table depth");

endmodule

@@ hdl/drt_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drt_dpath: table datapath
// Holds live and ready bits, the entry store, the scan result registers,
// the hold time register and the response register.
// ----------------------------------------------------------------------------
module drt_dpath #(
    parameter int ENTRIES = drt_pkg::ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  drt_pkg::t_dp_cmd              i_cmd,
    input  logic [$clog2(ENTRIES)-1:0]    i_rd_addr,
    input  logic [$clog2(ENTRIES)-1:0]    i_chk_idx,
    output drt_pkg::t_dp_sts              o_sts,
    input  logic                          i_cfg_we,
    input  logic [drt_pkg::HOLD_W-1:0]    i_cfg_wdata,
    input  drt_pkg::t_cmd                 i_command,
    input  logic [drt_pkg::MAC_W-1:0]     i_mac_addr,
    input  logic [drt_pkg::IFACE_W-1:0]   i_iface_id,
    input  logic [drt_pkg::HANDLE_W-1:0]  i_packet_handle,
    input  logic [drt_pkg::TIME_W-1:0]    i_now_time,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_status,
    output logic [drt_pkg::HANDLE_W-1:0]  o_handle_out,
    output logic [drt_pkg::MAC_W-1:0]     o_mac_out
);

    localparam int IDX_W = $clog2(ENTRIES);

    // Latched request
    drt_pkg::t_cmd                  r_command;
    logic [drt_pkg::MAC_W-1:0]      r_mac;
    logic [drt_pkg::IFACE_W-1:0]    r_iface;
    logic [drt_pkg::HANDLE_W-1:0]   r_handle;
    logic [drt_pkg::TIME_W-1:0]     r_now;

    // Table state
    logic [ENTRIES-1:0]             r_live;
    logic [ENTRIES-1:0]             r_ready;
    logic [drt_pkg::HOLD_W-1:0]     r_hold;

    // Scan results
    logic                           r_hit;
    logic [IDX_W-1:0]               r_hit_idx;
    logic                           r_free_hit;
    logic [IDX_W-1:0]               r_free_idx;
    logic [drt_pkg::HANDLE_W-1:0]   r_pop_handle;
    logic [drt_pkg::MAC_W-1:0]      r_pop_mac;

    // Response register
    logic                           r_out_valid;
    logic                           r_out_status;
    logic [drt_pkg::HANDLE_W-1:0]   r_out_handle;
    logic [drt_pkg::MAC_W-1:0]      r_out_mac;

    drt_pkg::t_entry                w_rd_entry;
    drt_pkg::t_entry                w_wr_entry;
    logic                           w_chk_live;
    logic                           w_chk_ready;
    logic                           w_mac_eq;
    logic                           w_iface_eq;
    logic [drt_pkg::TIME_W-1:0]     w_age;
    logic                           w_aged;
    logic                           w_take_match;
    logic                           w_take_free;
    logic                           w_take_pop;
    logic [IDX_W-1:0]               w_save_idx;
    logic                           w_save_ok;
    logic                           w_wr_en;

    // Entry store
    drt_ram #(
        .WIDTH ($bits(drt_pkg::t_entry)),
        .DEPTH (ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_wr_en),
        .i_waddr (w_save_idx),
        .i_wdata (w_wr_entry),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_rd_addr),
        .o_rdata (w_rd_entry)
    );

    // Per-entry checks on the returned read data
    assign w_chk_live  = r_live[i_chk_idx];
    assign w_chk_ready = r_ready[i_chk_idx];
    assign w_mac_eq    = (w_rd_entry.mac == r_mac);
    assign w_iface_eq  = (w_rd_entry.iface == r_iface);
    assign w_age       = r_now - w_rd_entry.stamp;
    assign w_aged      = (w_age > {{(drt_pkg::TIME_W - drt_pkg::HOLD_W){1'b0}}, r_hold});

    assign w_take_match = i_cmd.chk && !r_hit && w_chk_live && w_mac_eq &&
                          (r_command == drt_pkg::CMD_SAVE || r_command == drt_pkg::CMD_MARK);
    assign w_take_free  = i_cmd.chk && !r_free_hit && !w_chk_live &&
                          (r_command == drt_pkg::CMD_SAVE);
    assign w_take_pop   = i_cmd.chk && !r_hit && w_chk_live && w_chk_ready && w_iface_eq &&
                          (r_command == drt_pkg::CMD_POP);

    // Save target: matching live entry first, else lowest free one
    assign w_save_idx = r_hit ? r_hit_idx : r_free_idx;
    assign w_save_ok  = r_hit || r_free_hit;
    assign w_wr_en    = i_cmd.commit && (r_command == drt_pkg::CMD_SAVE) && w_save_ok;

    assign w_wr_entry.mac    = r_mac;
    assign w_wr_entry.iface  = r_iface;
    assign w_wr_entry.handle = r_handle;
    assign w_wr_entry.stamp  = r_now;

    assign o_sts.out_busy = r_out_valid && !i_out_ready;

    // Control state: live and ready bits, scan flags, hold time, response valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live      <= '0;
            r_ready     <= '0;
            r_hit       <= 1'b0;
            r_free_hit  <= 1'b0;
            r_hold      <= drt_pkg::HOLD_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_hold <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_hit      <= 1'b0;
                r_free_hit <= 1'b0;
            end
            if (w_take_match || w_take_pop) begin
                r_hit <= 1'b1;
            end
            if (w_take_free) begin
                r_free_hit <= 1'b1;
            end
            // drop aged entries during the tick sweep
            if (i_cmd.chk && r_command == drt_pkg::CMD_TICK && w_chk_live && w_aged) begin
                r_live[i_chk_idx] <= 1'b0;
            end
            // load a new response beat, else drop the one just taken
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.commit) begin
                unique case (r_command)
                    drt_pkg::CMD_SAVE: begin
                        if (w_save_ok) begin
                            r_live[w_save_idx] <= 1'b1;
                            if (!r_hit) begin
                                r_ready[w_save_idx] <= 1'b0;
                            end
                        end
                    end
                    drt_pkg::CMD_MARK: begin
                        if (r_hit) begin
                            r_ready[r_hit_idx] <= 1'b1;
                        end
                    end
                    drt_pkg::CMD_POP: begin
                        if (r_hit) begin
                            r_live[r_hit_idx] <= 1'b0;
                        end
                    end
                    drt_pkg::CMD_TICK: begin
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload: request latch, scan captures, response fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_command <= i_command;
            r_mac     <= i_mac_addr;
            r_iface   <= i_iface_id;
            r_handle  <= i_packet_handle;
            r_now     <= i_now_time;
        end
        if (w_take_match || w_take_pop) begin
            r_hit_idx <= i_chk_idx;
        end
        if (w_take_free) begin
            r_free_idx <= i_chk_idx;
        end
        if (w_take_pop) begin
            r_pop_handle <= w_rd_entry.handle;
            r_pop_mac    <= w_rd_entry.mac;
        end
        if (i_cmd.commit) begin
            // only a successful pop returns a handle and an address
            if (r_command == drt_pkg::CMD_POP && r_hit) begin
                r_out_handle <= r_pop_handle;
                r_out_mac    <= r_pop_mac;
            end else begin
                r_out_handle <= '0;
                r_out_mac    <= '0;
            end
            unique case (r_command)
                drt_pkg::CMD_SAVE: r_out_status <= !w_save_ok;
                drt_pkg::CMD_MARK: r_out_status <= !r_hit;
                drt_pkg::CMD_POP:  r_out_status <= !r_hit;
                drt_pkg::CMD_TICK: r_out_status <= 1'b0;
                default: r_out_status <= 1'b0;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_handle_out = r_out_handle;
    assign o_mac_out    = r_out_mac;

    a_commit_loads_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("commit did not load the response register");

    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status) |-> (r_out_handle == '0 && r_out_mac == '0))
        else $error("failed command returned a nonzero handle or address");

    a_store_write_on_save: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |=> r_live[$past(w_save_idx)])
        else $error("saved entry is not live after commit");

endmodule

@@ hdl/deferred_request_table.sv @@
`timescale 1ns / 1ps
// A request is latched, every entry is scanned, and the result is committed to
// the response register; the next request is accepted only after that commit.
// The scan reads the entry store once per entry through its single read port.
// A new request is taken while the previous response still waits to be taken.
// Reset (synchronous, active low) clears every live and ready bit and sets the
// hold time to 10; the entry store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// deferred_request_table: table of deferred client requests
// Save, mark ready, pop by interface and age out entries keyed by a
// 48-bit hardware address.
// ----------------------------------------------------------------------------
module deferred_request_table #(
    parameter int ENTRIES = drt_pkg::ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    drt_req_if.sink                     i_req,
    drt_rsp_if.source                   o_rsp,
    input  logic                        i_cfg_we,
    input  logic [drt_pkg::HOLD_W-1:0]  i_cfg_wdata
);

    localparam int IDX_W = $clog2(ENTRIES);

    drt_pkg::t_dp_cmd  w_cmd;
    drt_pkg::t_dp_sts  w_sts;
    logic [IDX_W-1:0]  w_rd_addr;
    logic [IDX_W-1:0]  w_chk_idx;

    // Sequencer
    drt_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_rd_addr  (w_rd_addr),
        .o_chk_idx  (w_chk_idx)
    );

    // Table state and response register
    drt_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_rd_addr       (w_rd_addr),
        .i_chk_idx       (w_chk_idx),
        .o_sts           (w_sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_command       (i_req.command),
        .i_mac_addr      (i_req.mac_addr),
        .i_iface_id      (i_req.iface_id),
        .i_packet_handle (i_req.packet_handle),
        .i_now_time      (i_req.now_time),
        .o_out_valid     (o_rsp.valid),
        .i_out_ready     (o_rsp.ready),
        .o_status        (o_rsp.status),
        .o_handle_out    (o_rsp.handle_out),
        .o_mac_out       (o_rsp.mac_out)
    );

endmodule

@@ bench/tb_deferred_request_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_deferred_request_table: self-checking bench of the deferred request table
// A queue-fed driver sends table commands in random bursts while a monitor
// takes responses under a shifting stall pattern. A behavioral copy of the
// table predicts every response, and the monitor checks each field in order.
// The hold time is rewritten between phases, with the table idle each time.
// ----------------------------------------------------------------------------
module tb_deferred_request_table;

    localparam int SLOTS    = drt_pkg::ENTRIES_DEF;
    localparam int MAC_POOL = 20;
    localparam int PHASES   = 6;
    localparam int PER_PHASE = 150;
    localparam int SETTLE   = drt_pkg::ENTRIES_DEF + 12;

    typedef struct {
        drt_pkg::t_cmd                cmd;
        logic [drt_pkg::MAC_W-1:0]    mac;
        logic [drt_pkg::IFACE_W-1:0]  iface;
        logic [drt_pkg::HANDLE_W-1:0] handle;
        logic [drt_pkg::TIME_W-1:0]   now;
    } t_table_cmd;

    typedef struct {
        logic                         status;
        logic [drt_pkg::HANDLE_W-1:0] handle;
        logic [drt_pkg::MAC_W-1:0]    mac;
    } t_table_result;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         cfg_we;
    logic [drt_pkg::HOLD_W-1:0]   cfg_wdata;

    drt_req_if req_ch();
    drt_rsp_if rsp_ch();

    deferred_request_table uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the table
    logic                         slot_live   [SLOTS];
    logic                         slot_ready  [SLOTS];
    logic [drt_pkg::MAC_W-1:0]    slot_mac    [SLOTS];
    logic [drt_pkg::IFACE_W-1:0]  slot_iface  [SLOTS];
    logic [drt_pkg::HANDLE_W-1:0] slot_handle [SLOTS];
    logic [drt_pkg::TIME_W-1:0]   slot_stamp  [SLOTS];
    logic [drt_pkg::HOLD_W-1:0]   hold_shadow;

    t_table_cmd    request_backlog [$];
    t_table_result pending_results [$];
    t_table_cmd    in_flight;

    int            burst_left;
    int            gap_left;
    int            stall_mode;
    int            stall_count;
    int            err_count;

    logic [drt_pkg::MAC_W-1:0]   mac_pool   [MAC_POOL];
    logic [drt_pkg::IFACE_W-1:0] iface_pool [4];
    logic [drt_pkg::TIME_W-1:0]  clk_now;
    int unsigned                 step_max;

    // Lowest live slot holding this address, or -1
    function automatic int find_live(logic [drt_pkg::MAC_W-1:0] mac);
        for (int i = 0; i < SLOTS; i++)
            if (slot_live[i] && slot_mac[i] == mac)
                return i;
        return -1;
    endfunction

    // Apply one command to the shadow table and return its response
    function automatic t_table_result apply_command(t_table_cmd it);
        t_table_result r;
        int            k;
        logic [drt_pkg::TIME_W-1:0] age;
        r.status = 1'b1;
        r.handle = '0;
        r.mac    = '0;
        case (it.cmd)
            drt_pkg::CMD_SAVE: begin
                k = find_live(it.mac);
                if (k < 0) begin
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!slot_live[i])
                            k = i;
                end
                if (k >= 0) begin
                    // keep the ready mark only when reusing a ready entry
                    if (!(slot_live[k] && slot_ready[k]))
                        slot_ready[k] = 1'b0;
                    slot_live[k]   = 1'b1;
                    slot_mac[k]    = it.mac;
                    slot_iface[k]  = it.iface;
                    slot_handle[k] = it.handle;
                    slot_stamp[k]  = it.now;
                    r.status = 1'b0;
                end
            end
            drt_pkg::CMD_MARK: begin
                k = find_live(it.mac);
                if (k >= 0) begin
                    slot_ready[k] = 1'b1;
                    r.status = 1'b0;
                end
            end
            drt_pkg::CMD_POP: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (r.status && slot_live[i] && slot_ready[i]
                            && slot_iface[i] == it.iface) begin
                        r.handle     = slot_handle[i];
                        r.mac        = slot_mac[i];
                        slot_live[i] = 1'b0;
                        r.status     = 1'b0;
                    end
                end
            end
            default: begin
                // age is taken modulo 2^32
                for (int i = 0; i < SLOTS; i++) begin
                    age = it.now - slot_stamp[i];
                    if (slot_live[i] && age > {16'd0, hold_shadow})
                        slot_live[i] = 1'b0;
                end
                r.status = 1'b0;
            end
        endcase
        return r;
    endfunction

    task automatic queue_request(drt_pkg::t_cmd cmd, logic [drt_pkg::MAC_W-1:0] mac,
                                 logic [drt_pkg::IFACE_W-1:0] iface,
                                 logic [drt_pkg::HANDLE_W-1:0] handle,
                                 logic [drt_pkg::TIME_W-1:0] now);
        t_table_cmd it;
        it.cmd    = cmd;
        it.mac    = mac;
        it.iface  = iface;
        it.handle = handle;
        it.now    = now;
        request_backlog.push_back(it);
    endtask

    // Random command, mostly on a small set of addresses and interfaces
    function automatic t_table_cmd make_random_request();
        t_table_cmd  it;
        int          roll;
        logic [63:0] wide;
        logic [31:0] rnd;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            it.cmd = drt_pkg::CMD_SAVE;
        else if (roll < 60)
            it.cmd = drt_pkg::CMD_MARK;
        else if (roll < 85)
            it.cmd = drt_pkg::CMD_POP;
        else
            it.cmd = drt_pkg::CMD_TICK;
        wide = {$urandom, $urandom};
        if ($urandom_range(0, 19) == 0)
            it.mac = wide[drt_pkg::MAC_W-1:0];
        else
            it.mac = mac_pool[$urandom_range(0, MAC_POOL - 1)];
        rnd = $urandom;
        if ($urandom_range(0, 19) == 0)
            it.iface = rnd[drt_pkg::IFACE_W-1:0];
        else
            it.iface = iface_pool[$urandom_range(0, 3)];
        rnd = $urandom;
        it.handle = rnd[drt_pkg::HANDLE_W-1:0];
        // advance the clock, with rare jumps and runs up to the wrap point
        roll = $urandom_range(0, 99);
        if (roll < 2)
            clk_now = $urandom;
        else if (roll < 3)
            clk_now = 32'hFFFF_FFFF - $urandom_range(0, 20);
        else
            clk_now = clk_now + $urandom_range(0, step_max);
        it.now = ($urandom_range(0, 29) == 0) ? $urandom : clk_now;
        return it;
    endfunction

    // Hold until the backlog is sent and every response has come back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (request_backlog.size() != 0 || req_ch.valid
               || pending_results.size() != 0);
    endtask

    task automatic load_hold_time(logic [drt_pkg::HOLD_W-1:0] value);
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        hold_shadow = value;
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    // Request driver: bursts of random length separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (req_ch.valid && req_ch.ready)
                pending_results.push_back(apply_command(in_flight));
            if (!req_ch.valid || req_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end else if (request_backlog.size() > 0) begin
                    in_flight = request_backlog.pop_front();
                    req_ch.valid         <= 1'b1;
                    req_ch.command       <= in_flight.cmd;
                    req_ch.mac_addr      <= in_flight.mac;
                    req_ch.iface_id      <= in_flight.iface;
                    req_ch.packet_handle <= in_flight.handle;
                    req_ch.now_time      <= in_flight.now;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor: check each beat, stall on a shifting pattern
    always @(posedge i_clk) begin : rsp_monitor
        t_table_result want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            stall_mode  = 0;
            stall_count = 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (pending_results.size() == 0) begin
                    err_count++;
                    $display("%0t: response beat with no command outstanding, got %b %h %h",
                             $time, rsp_ch.status, rsp_ch.handle_out, rsp_ch.mac_out);
                end else begin
                    want = pending_results.pop_front();
                    if (rsp_ch.status !== want.status) begin
                        err_count++;
                        $display("%0t: status expected %b, got %b",
                                 $time, want.status, rsp_ch.status);
                    end
                    if (rsp_ch.handle_out !== want.handle) begin
                        err_count++;
                        $display("%0t: handle_out expected %h, got %h",
                                 $time, want.handle, rsp_ch.handle_out);
                    end
                    if (rsp_ch.mac_out !== want.mac) begin
                        err_count++;
                        $display("%0t: mac_out expected %h, got %h",
                                 $time, want.mac, rsp_ch.mac_out);
                    end
                end
            end
            stall_count++;
            if (stall_count % 80 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0:       rsp_ch.ready <= 1'b1;
                1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                2:       rsp_ch.ready <= (stall_count % 4 == 0);
                default: rsp_ch.ready <= (stall_count % 16) >= 10;
            endcase
        end
    end

    // Sequence: reset, directed commands, then random phases
    initial begin
        int          ph;
        int          n;
        logic [63:0] wide;
        logic [31:0] rnd;
        logic [drt_pkg::HOLD_W-1:0] hold_value;

        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        req_ch.valid         = 1'b0;
        req_ch.command       = drt_pkg::CMD_SAVE;
        req_ch.mac_addr      = '0;
        req_ch.iface_id      = '0;
        req_ch.packet_handle = '0;
        req_ch.now_time      = '0;
        rsp_ch.ready         = 1'b0;
        err_count            = 0;
        clk_now              = '0;
        step_max             = 4;
        hold_shadow          = drt_pkg::HOLD_RESET;
        for (int i = 0; i < SLOTS; i++) begin
            slot_live[i]  = 1'b0;
            slot_ready[i] = 1'b0;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: misses on an empty table, extremes, kept ready mark,
        // cleared mark after reuse of a freed slot, full table, aging
        queue_request(drt_pkg::CMD_POP,  '0, 8'd0, '0, '0);
        queue_request(drt_pkg::CMD_MARK, 48'd5, '0, '0, '0);
        queue_request(drt_pkg::CMD_TICK, '0, '0, '0, 32'd0);
        queue_request(drt_pkg::CMD_SAVE, '0, 8'd0, 16'd0, 32'd0);
        queue_request(drt_pkg::CMD_SAVE, '1, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
        queue_request(drt_pkg::CMD_MARK, '1, '0, '0, '0);
        queue_request(drt_pkg::CMD_SAVE, '1, 8'hFF, 16'h1234, 32'd3);
        queue_request(drt_pkg::CMD_POP,  '0, 8'hFF, '0, '0);
        queue_request(drt_pkg::CMD_SAVE, 48'd1, 8'hFF, 16'd1, 32'd4);
        queue_request(drt_pkg::CMD_POP,  '0, 8'hFF, '0, '0);
        for (int i = 2; i < SLOTS; i++)
            queue_request(drt_pkg::CMD_SAVE, 48'(i), 8'hFF, 16'(i), 32'(i));
        queue_request(drt_pkg::CMD_SAVE, 48'h5555_AAAA_5555, 8'h0F, 16'hBEEF, 32'd17);
        queue_request(drt_pkg::CMD_SAVE, '0, 8'h80, 16'h8001, 32'd20);
        queue_request(drt_pkg::CMD_TICK, '0, '0, '0, 32'd16);

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       hold_value = 16'd0;
                1:       hold_value = 16'hFFFF;
                2:       hold_value = 16'd7;
                3:       hold_value = 16'($urandom_range(1, 200));
                4:       hold_value = 16'd1;
                default: hold_value = drt_pkg::HOLD_RESET;
            endcase
            load_hold_time(hold_value);
            step_max = hold_value / 3 + 2;

            // fresh address and interface sets, extremes included
            mac_pool[0] = '0;
            mac_pool[1] = '1;
            for (int i = 2; i < MAC_POOL; i++) begin
                wide = {$urandom, $urandom};
                mac_pool[i] = wide[drt_pkg::MAC_W-1:0];
            end
            iface_pool[0] = 8'h00;
            iface_pool[1] = 8'hFF;
            rnd = $urandom;
            iface_pool[2] = rnd[7:0];
            iface_pool[3] = rnd[15:8];

            for (n = 0; n < PER_PHASE; n++) begin
                // halfway through one phase, pause the sender until drained
                if (ph == 2 && n == PER_PHASE / 2)
                    wait_drained();
                request_backlog.push_back(make_random_request());
            end
        end

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/drt_pkg.sv
hdl/drt_req_if.sv
hdl/drt_rsp_if.sv
hdl/drt_ram.sv
hdl/drt_ctrl.sv
hdl/drt_dpath.sv
hdl/deferred_request_table.sv
bench/tb_deferred_request_table.sv
